@@ hw/rtl/oers_pkg.sv @@
// shared widths and saturating fixed point helpers for the ode stepper
package oers_pkg;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned STEP_W = 7;
  localparam int unsigned DIV_W  = 33;
  localparam int unsigned DEN_W  = 7;

  localparam logic signed [DATA_W-1:0] Q_MAX = 32'sh7fffffff;
  localparam logic signed [DATA_W-1:0] Q_MIN = 32'sh80000000;

  localparam logic [DEN_W-1:0] SIX = 7'd6;

  function automatic logic signed [DATA_W-1:0] qadd(input logic signed [DATA_W-1:0] a,
                                                    input logic signed [DATA_W-1:0] b);
    logic signed [DATA_W:0] s;
    s = {a[DATA_W-1], a} + {b[DATA_W-1], b};
    if (s[DATA_W] != s[DATA_W-1]) begin
      qadd = s[DATA_W] ? Q_MIN : Q_MAX;
    end else begin
      qadd = s[DATA_W-1:0];
    end
  endfunction

endpackage

@@ hw/rtl/oers_mul.sv @@
// bit-serial signed fixed point multiplier with rounding and saturation
module oers_mul #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  start_i,
  input  logic signed [oers_pkg::DATA_W-1:0]    a_i,
  input  logic signed [oers_pkg::DATA_W-1:0]    b_i,
  output logic                                  done_o,
  output logic signed [oers_pkg::DATA_W-1:0]    res_o
);

  localparam int unsigned W = oers_pkg::DATA_W;
  localparam logic signed [2*W-1:0] RND = 64'sd1 <<< (FRAC_BITS - 1);

  typedef enum logic [1:0] {S_IDLE, S_RUN, S_NEG, S_RND} state_e;

  state_e               state_q;
  logic [W-1:0]         am_q;
  logic [W:0]           hi_q;
  logic [W-1:0]         lo_q;
  logic [4:0]           cnt_q;
  logic                 neg_q;
  logic signed [2*W-1:0] prod_q;
  logic                 done_q;
  logic signed [W-1:0]  res_q;

  logic [W+1:0]          sum;
  logic [W-1:0]          amag;
  logic [W-1:0]          bmag;
  logic [2*W-1:0]        mag;
  logic signed [2*W-1:0] rv;
  logic signed [2*W-1:0] sh;

  always_comb begin
    amag = a_i[W-1] ? (~a_i + 1'b1) : a_i;
    bmag = b_i[W-1] ? (~b_i + 1'b1) : b_i;
    sum  = {1'b0, hi_q} + (lo_q[0] ? {2'b00, am_q} : '0);
    mag  = {hi_q[W-1:0], lo_q};
    rv   = prod_q + RND;
    sh   = rv >>> FRAC_BITS;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
      cnt_q   <= '0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (start_i) begin
            am_q    <= amag;
            lo_q    <= bmag;
            hi_q    <= '0;
            neg_q   <= a_i[W-1] ^ b_i[W-1];
            cnt_q   <= '0;
            state_q <= S_RUN;
          end
        end
        S_RUN: begin
          hi_q  <= sum[W+1:1];
          lo_q  <= {sum[0], lo_q[W-1:1]};
          cnt_q <= cnt_q + 5'd1;
          if (cnt_q == 5'd31) begin
            state_q <= S_NEG;
          end
        end
        S_NEG: begin
          prod_q  <= neg_q ? -$signed(mag) : $signed(mag);
          state_q <= S_RND;
        end
        S_RND: begin
          if (sh > 64'sh7fffffff) begin
            res_q <= oers_pkg::Q_MAX;
          end else if (sh < -64'sh80000000) begin
            res_q <= oers_pkg::Q_MIN;
          end else begin
            res_q <= sh[W-1:0];
          end
          done_q  <= 1'b1;
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

@@ hw/rtl/oers_div.sv @@
// bit-serial restoring divider, truncates toward zero and saturates
module oers_div (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  start_i,
  input  logic signed [oers_pkg::DIV_W-1:0]     num_i,
  input  logic [oers_pkg::DEN_W-1:0]            den_i,
  output logic                                  done_o,
  output logic signed [oers_pkg::DATA_W-1:0]    res_o
);

  localparam int unsigned N = oers_pkg::DIV_W;
  localparam int unsigned D = oers_pkg::DEN_W;

  typedef enum logic [1:0] {S_IDLE, S_RUN, S_FIN} state_e;

  state_e              state_q;
  logic [N-1:0]        mag_q;
  logic [D:0]          rem_q;
  logic [D-1:0]        den_q;
  logic [5:0]          cnt_q;
  logic                neg_q;
  logic                done_q;
  logic signed [oers_pkg::DATA_W-1:0] res_q;

  logic [D:0]          r;
  logic                qb;
  logic [D:0]          rn;
  logic [N-1:0]        nmag;
  logic signed [N:0]   q;

  always_comb begin
    r    = {rem_q[D-1:0], mag_q[N-1]};
    qb   = (r >= {1'b0, den_q});
    rn   = qb ? (r - {1'b0, den_q}) : r;
    nmag = num_i[N-1] ? (~num_i + 1'b1) : num_i;
    q    = neg_q ? -$signed({1'b0, mag_q}) : $signed({1'b0, mag_q});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
      cnt_q   <= '0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (start_i) begin
            mag_q   <= nmag;
            rem_q   <= '0;
            den_q   <= den_i;
            neg_q   <= num_i[N-1];
            cnt_q   <= '0;
            state_q <= S_RUN;
          end
        end
        S_RUN: begin
          rem_q <= rn;
          mag_q <= {mag_q[N-2:0], qb};
          cnt_q <= cnt_q + 6'd1;
          if (cnt_q == 6'(N - 1)) begin
            state_q <= S_FIN;
          end
        end
        S_FIN: begin
          if (q > 34'sh07fffffff) begin
            res_q <= oers_pkg::Q_MAX;
          end else if (q < -34'sh080000000) begin
            res_q <= oers_pkg::Q_MIN;
          end else begin
            res_q <= q[oers_pkg::DATA_W-1:0];
          end
          done_q  <= 1'b1;
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

@@ hw/rtl/ode_euler_rk4_stepper.sv @@
// ode stepper top: euler or rk4 on dy/dx = 0.5*(1+x)*y^2, one word per step
// a run first divides out the step size, then takes an euler or rk4 step per
// word; one run at a time
// time is set by the bit-serial multiplier and divider
// results are strobed on valid_o for one cycle; the receiver cannot stall
// reset clears the sequencer, counters, busy, x, y, h; the rest is not reset
module ode_euler_rk4_stepper #(
  parameter int unsigned MAX_STEPS = 64,
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start,
  output logic                               busy,
  input  logic                               operation_i,
  input  logic signed [oers_pkg::DATA_W-1:0] x_start_i,
  input  logic signed [oers_pkg::DATA_W-1:0] y_start_i,
  input  logic signed [oers_pkg::DATA_W-1:0] x_end_i,
  input  logic [oers_pkg::STEP_W-1:0]        step_count_i,
  output logic                               valid_o,
  output logic [oers_pkg::STEP_W-1:0]        step_index_o,
  output logic signed [oers_pkg::DATA_W-1:0] x_value_o,
  output logic signed [oers_pkg::DATA_W-1:0] y_value_o,
  output logic                               last_o
);

  localparam int unsigned W  = oers_pkg::DATA_W;
  localparam int unsigned SW = oers_pkg::STEP_W;
  localparam logic signed [W-1:0] ONE  = W'(64'd1 << FRAC_BITS);
  localparam logic signed [W-1:0] HALF = W'(64'd1 << (FRAC_BITS - 1));
  localparam logic [SW-1:0] NMAX = SW'(MAX_STEPS);

  typedef enum logic [3:0] {
    S_IDLE, S_DIVH, S_HH, S_SL1, S_SL2, S_SL3, S_EUM, S_M1, S_H1, S_M2, S_M3,
    S_SUM1, S_SUM2, S_MS, S_D6, S_FIN
  } state_e;

  typedef enum logic [2:0] {R_EU, R_K1, R_K2, R_K3, R_K4} ret_e;

  state_e              state_q;
  ret_e                ret_q;
  logic                pend_q;
  logic                hsel_q;
  logic                meth_q;
  logic [SW-1:0]       n_q;
  logic [SW-1:0]       i_q;
  logic signed [W-1:0] x_q, y_q, xe_q, h_q, xm_q, sx_q, sy_q, t_q;
  logic signed [W-1:0] k1_q, k2_q, k3_q, sa_q, sb_q;
  logic                busy_q;
  logic                valid_q, last_q;
  logic [SW-1:0]       idx_q;
  logic signed [W-1:0] xo_q, yo_q;

  logic                accept;
  logic [SW-1:0]       n_in;
  logic                is_mul, is_div;
  logic                mul_go, div_go, mul_done, div_done;
  logic signed [W-1:0] mul_a, mul_b, mul_res, div_res;
  logic signed [oers_pkg::DIV_W-1:0] div_num;
  logic [oers_pkg::DEN_W-1:0]        div_den;

  assign accept = start && !busy_q;
  assign n_in   = (step_count_i > NMAX) ? NMAX : step_count_i;

  always_comb begin
    is_mul = 1'b0;
    is_div = 1'b0;
    mul_a  = h_q;
    mul_b  = HALF;
    div_num = {xe_q[W-1], xe_q} - {x_q[W-1], x_q};
    div_den = n_q;
    case (state_q)
      S_DIVH: is_div = 1'b1;
      S_HH:   is_mul = 1'b1;
      S_SL1: begin
        is_mul = 1'b1;
        mul_a  = sy_q;
        mul_b  = sy_q;
      end
      S_SL2: begin
        is_mul = 1'b1;
        mul_a  = oers_pkg::qadd(ONE, sx_q);
        mul_b  = t_q;
      end
      S_SL3: begin
        is_mul = 1'b1;
        mul_a  = t_q;
      end
      S_EUM: begin
        is_mul = 1'b1;
        mul_b  = t_q;
      end
      S_M1: begin
        is_mul = 1'b1;
        mul_b  = k1_q;
      end
      S_H1: begin
        is_mul = 1'b1;
        mul_a  = t_q;
      end
      S_M2: begin
        is_mul = 1'b1;
        mul_b  = k2_q;
      end
      S_M3: begin
        is_mul = 1'b1;
        mul_b  = k3_q;
      end
      S_MS: begin
        is_mul = 1'b1;
        mul_a  = t_q;
        mul_b  = h_q;
      end
      S_D6: begin
        is_div  = 1'b1;
        div_num = {t_q[W-1], t_q};
        div_den = oers_pkg::SIX;
      end
      default: ;
    endcase
  end

  assign mul_go = is_mul && !pend_q;
  assign div_go = is_div && !pend_q;

  oers_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_go),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .res_o   (mul_res)
  );

  oers_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_go),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .res_o   (div_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ret_q   <= R_EU;
      pend_q  <= 1'b0;
      busy_q  <= 1'b0;
      valid_q <= 1'b0;
      last_q  <= 1'b0;
      hsel_q  <= 1'b0;
      meth_q  <= 1'b0;
      n_q     <= '0;
      i_q     <= '0;
      idx_q   <= '0;
      x_q     <= '0;
      y_q     <= '0;
      h_q     <= '0;
    end else begin
      valid_q <= 1'b0;
      if (mul_go || div_go) begin
        pend_q <= 1'b1;
      end
      if (mul_done || div_done) begin
        pend_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            meth_q <= operation_i;
            x_q    <= x_start_i;
            y_q    <= y_start_i;
            xe_q   <= x_end_i;
            n_q    <= n_in;
            i_q    <= '0;
            if (n_in == '0) begin
              h_q <= '0;
            end else begin
              busy_q  <= 1'b1;
              state_q <= S_DIVH;
            end
          end
        end
        S_DIVH: begin
          if (div_done) begin
            h_q  <= div_res;
            sx_q <= x_q;
            sy_q <= y_q;
            ret_q <= R_EU;
            state_q <= meth_q ? S_HH : S_SL1;
          end
        end
        S_HH: begin
          if (mul_done) begin
            xm_q  <= oers_pkg::qadd(x_q, mul_res);
            sx_q  <= x_q;
            sy_q  <= y_q;
            ret_q <= R_K1;
            state_q <= S_SL1;
          end
        end
        S_SL1: begin
          if (mul_done) begin
            t_q <= mul_res;
            state_q <= S_SL2;
          end
        end
        S_SL2: begin
          if (mul_done) begin
            t_q <= mul_res;
            state_q <= S_SL3;
          end
        end
        S_SL3: begin
          if (mul_done) begin
            case (ret_q)
              R_K1: begin
                k1_q <= mul_res;
                state_q <= S_M1;
              end
              R_K2: begin
                k2_q <= mul_res;
                state_q <= S_M2;
              end
              R_K3: begin
                k3_q <= mul_res;
                state_q <= S_M3;
              end
              R_K4: begin
                t_q <= mul_res;
                state_q <= S_SUM1;
              end
              default: begin
                t_q <= mul_res;
                state_q <= S_EUM;
              end
            endcase
          end
        end
        S_EUM: begin
          if (mul_done) begin
            t_q <= oers_pkg::qadd(y_q, mul_res);
            state_q <= S_FIN;
          end
        end
        S_M1: begin
          if (mul_done) begin
            t_q <= mul_res;
            hsel_q <= 1'b0;
            state_q <= S_H1;
          end
        end
        S_M2: begin
          if (mul_done) begin
            t_q <= mul_res;
            hsel_q <= 1'b1;
            state_q <= S_H1;
          end
        end
        S_H1: begin
          if (mul_done) begin
            sy_q  <= oers_pkg::qadd(y_q, mul_res);
            sx_q  <= xm_q;
            ret_q <= hsel_q ? R_K3 : R_K2;
            state_q <= S_SL1;
          end
        end
        S_M3: begin
          if (mul_done) begin
            sy_q  <= oers_pkg::qadd(y_q, mul_res);
            sx_q  <= oers_pkg::qadd(x_q, h_q);
            ret_q <= R_K4;
            state_q <= S_SL1;
          end
        end
        S_SUM1: begin
          sa_q <= oers_pkg::qadd(k1_q, oers_pkg::qadd(k2_q, k2_q));
          sb_q <= oers_pkg::qadd(oers_pkg::qadd(k3_q, k3_q), t_q);
          state_q <= S_SUM2;
        end
        S_SUM2: begin
          t_q <= oers_pkg::qadd(sa_q, sb_q);
          state_q <= S_MS;
        end
        S_MS: begin
          if (mul_done) begin
            t_q <= mul_res;
            state_q <= S_D6;
          end
        end
        S_D6: begin
          if (div_done) begin
            t_q <= oers_pkg::qadd(y_q, div_res);
            state_q <= S_FIN;
          end
        end
        S_FIN: begin
          x_q     <= oers_pkg::qadd(x_q, h_q);
          y_q     <= t_q;
          sx_q    <= oers_pkg::qadd(x_q, h_q);
          sy_q    <= t_q;
          i_q     <= i_q + 1'b1;
          valid_q <= 1'b1;
          idx_q   <= i_q + 1'b1;
          xo_q    <= oers_pkg::qadd(x_q, h_q);
          yo_q    <= t_q;
          last_q  <= (i_q + 1'b1) == n_q;
          ret_q   <= R_EU;
          if ((i_q + 1'b1) == n_q) begin
            busy_q  <= 1'b0;
            state_q <= S_IDLE;
          end else begin
            state_q <= meth_q ? S_HH : S_SL1;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign busy         = busy_q;
  assign valid_o      = valid_q;
  assign step_index_o = idx_q;
  assign x_value_o    = xo_q;
  assign y_value_o    = yo_q;
  assign last_o       = last_q;

  a_idx_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> step_index_o != '0) else $error("zero step index");

  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && last_o) |-> !busy) else $error("busy after last step");

  a_strobe_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |=> !valid_o) else $error("back to back words");

  a_run_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && step_count_i != '0) |=> busy) else $error("run not started");

endmodule

@@ test/testbench.sv @@
// self-checking testbench for the euler / rk4 ode stepper
`timescale 1ns / 1ps

module testbench;

  typedef struct packed {
    logic [oers_pkg::STEP_W-1:0]        idx;
    logic signed [oers_pkg::DATA_W-1:0] x;
    logic signed [oers_pkg::DATA_W-1:0] y;
    logic                               last;
  } step_word_t;

  typedef struct {
    logic                               method;
    logic signed [oers_pkg::DATA_W-1:0] xs;
    logic signed [oers_pkg::DATA_W-1:0] ys;
    logic signed [oers_pkg::DATA_W-1:0] xe;
    logic [oers_pkg::STEP_W-1:0]        n;
    bit                                 typed;
    step_word_t                         typed_word;
  } run_row_t;

  localparam int unsigned FB = 16;
  localparam int unsigned NMAX = 64;
  localparam logic EULER = 1'b0;
  localparam logic RK4 = 1'b1;

  logic                               clk_i = 1'b0;
  logic                               rst_ni = 1'b0;
  logic                               start = 1'b0;
  logic                               busy;
  logic                               operation_i = 1'b0;
  logic signed [oers_pkg::DATA_W-1:0] x_start_i = '0;
  logic signed [oers_pkg::DATA_W-1:0] y_start_i = '0;
  logic signed [oers_pkg::DATA_W-1:0] x_end_i = '0;
  logic [oers_pkg::STEP_W-1:0]        step_count_i = '0;
  logic                               valid_o;
  logic [oers_pkg::STEP_W-1:0]        step_index_o;
  logic signed [oers_pkg::DATA_W-1:0] x_value_o;
  logic signed [oers_pkg::DATA_W-1:0] y_value_o;
  logic                               last_o;

  step_word_t step_q[$];
  int         mismatches = 0;
  int         words_seen = 0;
  int         runs_sent = 0;

  ode_euler_rk4_stepper dut (.*);

  always #5 clk_i = ~clk_i;

  function automatic longint sat64(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint fx_mul(longint a, longint b);
    longint p;
    p = a * b + (64'sd1 <<< (FB - 1));
    return sat64(p >>> FB);
  endfunction

  function automatic longint fx_half(longint a);
    return fx_mul(a, 64'sd1 <<< (FB - 1));
  endfunction

  function automatic longint dydx(longint x, longint y);
    return fx_half(fx_mul(sat64((64'sd1 <<< FB) + x), fx_mul(y, y)));
  endfunction

  task automatic predict_run(run_row_t r);
    longint x, y, h, xm, k1, k2, k3, k4, s;
    int n;
    step_word_t w;
    x = r.xs;
    y = r.ys;
    n = r.n;
    if (n > NMAX) n = NMAX;
    h = (n == 0) ? 0 : sat64((longint'(r.xe) - x) / n);
    for (int i = 1; i <= n; i++) begin
      if (r.method == EULER) begin
        y = sat64(y + fx_mul(h, dydx(x, y)));
      end else begin
        xm = sat64(x + fx_half(h));
        k1 = dydx(x, y);
        k2 = dydx(xm, sat64(y + fx_half(fx_mul(h, k1))));
        k3 = dydx(xm, sat64(y + fx_half(fx_mul(h, k2))));
        k4 = dydx(sat64(x + h), sat64(y + fx_mul(h, k3)));
        s = sat64(sat64(k1 + sat64(k2 + k2)) + sat64(sat64(k3 + k3) + k4));
        y = sat64(y + sat64(fx_mul(s, h) / 6));
      end
      x = sat64(x + h);
      w.idx = i[oers_pkg::STEP_W-1:0];
      w.x = x[31:0];
      w.y = y[31:0];
      w.last = (i == n);
      step_q.push_back(w);
    end
  endtask

  task automatic send_run(run_row_t r);
    @(negedge clk_i);
    while (busy) @(negedge clk_i);
    operation_i <= r.method;
    x_start_i <= r.xs;
    y_start_i <= r.ys;
    x_end_i <= r.xe;
    step_count_i <= r.n;
    start <= 1'b1;
    @(posedge clk_i);
    predict_run(r);
    if (r.typed && step_q.size() > 0) begin
      if (step_q[0] != r.typed_word) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("typed first word differs: table %p predictor %p", r.typed_word, step_q[0]);
        end
      end
    end
    runs_sent++;
    @(negedge clk_i);
    start <= 1'b0;
  endtask

  always @(posedge clk_i) begin
    step_word_t got, want;
    if (valid_o) begin
      got = '{step_index_o, x_value_o, y_value_o, last_o};
      words_seen++;
      if (step_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word %p", got);
      end else begin
        want = step_q.pop_front();
        if (got != want) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p actual %p", want, got);
        end
      end
    end
  end

  function automatic logic signed [oers_pkg::DATA_W-1:0] rnd_q();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return oers_pkg::Q_MAX - $urandom_range(0, 3);
      2: return oers_pkg::Q_MIN + $urandom_range(0, 3);
      default: return $signed($urandom_range(0, 32'h0006_0000)) - 32'sh0003_0000;
    endcase
  endfunction

  run_row_t dir_tab[$];
  run_row_t r;

  initial begin
    #500_000_000;
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    dir_tab.push_back('{EULER, 0, 0, 32'sh0001_0000, 1, 1, '{1, 32'sh0001_0000, 0, 1}});
    dir_tab.push_back('{RK4, 0, 0, 32'sh0001_0000, 1, 1, '{1, 32'sh0001_0000, 0, 1}});
    dir_tab.push_back('{EULER, 0, 32'sh0000_8000, 32'sh0001_0000, 4, 0, '0});
    dir_tab.push_back('{RK4, 0, 32'sh0000_8000, 32'sh0001_0000, 4, 0, '0});
    dir_tab.push_back('{EULER, 0, 32'sh0001_0000, 32'sh0001_0000, 0, 0, '0});
    dir_tab.push_back('{RK4, 0, 32'sh0001_0000, 32'sh0001_0000, 0, 0, '0});
    dir_tab.push_back('{EULER, 0, 32'sh0000_1000, 32'sh0002_0000, 64, 0, '0});
    dir_tab.push_back('{RK4, 0, 32'sh0000_1000, 32'sh0002_0000, 64, 0, '0});
    dir_tab.push_back('{EULER, 0, 32'sh0000_1000, 32'sh0002_0000, 127, 0, '0});
    dir_tab.push_back('{RK4, 0, 32'sh0000_1000, 32'sh0002_0000, 100, 0, '0});
    dir_tab.push_back('{EULER, oers_pkg::Q_MIN, oers_pkg::Q_MAX, oers_pkg::Q_MAX, 1, 0, '0});
    dir_tab.push_back('{RK4, oers_pkg::Q_MIN, oers_pkg::Q_MAX, oers_pkg::Q_MAX, 1, 0, '0});
    dir_tab.push_back('{EULER, oers_pkg::Q_MAX, oers_pkg::Q_MIN, oers_pkg::Q_MIN, 2, 0, '0});
    dir_tab.push_back('{RK4, oers_pkg::Q_MAX, oers_pkg::Q_MIN, oers_pkg::Q_MIN, 3, 0, '0});
    dir_tab.push_back('{EULER, oers_pkg::Q_MAX, oers_pkg::Q_MAX, oers_pkg::Q_MAX, 1, 0, '0});
    dir_tab.push_back('{RK4, oers_pkg::Q_MIN, oers_pkg::Q_MIN, oers_pkg::Q_MIN, 1, 0, '0});
    dir_tab.push_back('{RK4, -32'sh0003_0000, 32'sh0004_0000, 32'sh0003_0000, 5, 0, '0});
    dir_tab.push_back('{EULER, -1, -1, -1, 7'h7f, 0, '0});
    foreach (dir_tab[i]) send_run(dir_tab[i]);

    while (runs_sent < 200) begin
      repeat ($urandom_range(1, 8)) begin
        r.method = $urandom_range(0, 1);
        r.xs = rnd_q();
        r.ys = rnd_q();
        r.xe = rnd_q();
        case ($urandom_range(0, 9))
          0: r.n = $urandom_range(0, 127);
          1: r.n = $urandom_range(17, 64);
          default: r.n = $urandom_range(1, 6);
        endcase
        r.typed = 0;
        r.typed_word = '0;
        send_run(r);
      end
      if ($urandom_range(0, 4) == 0) begin
        while (step_q.size() > 0) @(posedge clk_i);
      end else begin
        repeat ($urandom_range(0, 40)) @(negedge clk_i);
      end
    end

    while (step_q.size() > 0) @(posedge clk_i);
    @(negedge clk_i);
    while (busy) @(negedge clk_i);
    repeat (100) @(posedge clk_i);
    $display("ran %0d runs of both methods, checked %0d step words", runs_sent, words_seen);
    if (mismatches == 0 && step_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

@@ files.f @@
hw/rtl/oers_pkg.sv
hw/rtl/oers_mul.sv
hw/rtl/oers_div.sv
hw/rtl/ode_euler_rk4_stepper.sv
test/testbench.sv
